// File: hw/rtl/dra_pkg.sv
package dra_pkg;

    localparam int unsigned HeaderBytes  = 12;
    localparam int unsigned RrFixedBytes = 10;
    localparam int unsigned QFixedBytes  = 4;
    localparam int unsigned ALen         = 4;

    localparam logic [7:0]  PTR_MASK = 8'hC0;
    localparam logic [15:0] TYPE_A   = 16'd1;

    localparam logic [3:0] HDR_FLAGS_OFF = 4'd2;
    localparam logic [3:0] HDR_ANCNT_HI  = 4'd6;
    localparam logic [3:0] HDR_ANCNT_LO  = 4'd7;
    localparam logic [3:0] HDR_LAST_OFF  = 4'(HeaderBytes - 1);

    localparam logic [3:0] RR_TYPE_HI  = 4'd0;
    localparam logic [3:0] RR_TYPE_LO  = 4'd1;
    localparam logic [3:0] RR_LEN_HI   = 4'd8;
    localparam logic [3:0] RR_LEN_LO   = 4'd9;
    localparam logic [3:0] RR_LAST_OFF = 4'(RrFixedBytes - 1);

    localparam logic [3:0]  ADDR_LAST_OFF = 4'(ALen - 1);
    localparam logic [15:0] Q_FIXED_SKIP  = 16'(QFixedBytes);
    localparam logic [15:0] A_LEN_VAL     = 16'(ALen);

    typedef struct packed {
        logic        resolved;
        logic [31:0] address;
    } dra_result_t;

endpackage

// File: hw/rtl/dns_response_a_record_extract.sv
// DNS response A-record extractor.
// Input channel (byte_valid/byte_stall): one request per payload byte, data_byte
// with last_byte set on the final byte. Requests may arrive every cycle.
// Output channel (result_valid/result_stall): one result per payload, given
// for the request that carries last_byte: resolved and the 32-bit address
// (first address byte in bits 31..24, zero when not resolved).
// Each byte is captured in an input register and consumed by the parser from
// there; the parser's next-state logic also forms the result, which is loaded
// into the result register, the source of result_valid, when the last byte is
// consumed. Throughput is one byte per cycle while byte_stall is low.
// While result_stall holds a pending result, ordinary bytes keep flowing;
// only a further last byte waits in the input register, and byte_stall is
// raised until the result register frees up.
// Reset clears the parser to the header phase and empties both registers.
module dns_response_a_record_extract
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        resolved,
    output logic [31:0] address
);

    logic        hold_valid_reg;
    logic [7:0]  hold_byte_reg;
    logic        hold_last_reg;
    logic        out_valid_reg;
    dra_result_t out_reg;
    dra_result_t parse_result;
    logic        out_free;
    logic        consume;

    assign out_free   = !out_valid_reg || !result_stall;
    assign consume    = hold_valid_reg && (!hold_last_reg || out_free);
    assign byte_stall = hold_valid_reg && !consume;

    dra_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (consume),
        .data_byte (hold_byte_reg),
        .last_byte (hold_last_reg),
        .result    (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                hold_valid_reg <= 1'b1;
            else if (consume)
                hold_valid_reg <= 1'b0;

            if (consume && hold_last_reg)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            hold_byte_reg <= data_byte;
            hold_last_reg <= last_byte;
        end
        if (consume && hold_last_reg)
            out_reg <= parse_result;
    end

    assign result_valid = out_valid_reg;
    assign resolved     = out_reg.resolved;
    assign address      = out_reg.address;

    a_zero_when_unresolved: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !resolved |-> address == 32'd0)
        else $error("address not zero for unresolved result");

    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> hold_last_reg && result_valid && result_stall)
        else $error("input stalled without a blocked result");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        consume && hold_last_reg |=> result_valid)
        else $error("last byte consumed without a result");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        consume && hold_last_reg |-> !result_valid || !result_stall)
        else $error("result overwritten while stalled");

endmodule

// File: hw/rtl/dra_parse.sv
module dra_parse
    import dra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output dra_result_t result
);

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QPTR,
        PH_QFIXED,
        PH_ANAME,
        PH_APTR,
        PH_AFIXED,
        PH_ADATA,
        PH_ADDR
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [3:0]  offset_reg,  offset_next;
    logic [15:0] skip_reg,    skip_next;
    logic [15:0] answers_reg, answers_next;
    logic        is_resp_reg, is_resp_next;
    logic [15:0] rtype_reg,   rtype_next;
    logic [15:0] rlen_reg,    rlen_next;
    logic [31:0] accum_reg,   accum_next;
    logic        found_reg,   found_next;
    logic        stopped_reg, stopped_next;
    logic [15:0] skip_dec;

    assign skip_dec = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next   = phase_reg;
        offset_next  = offset_reg;
        skip_next    = skip_reg;
        answers_next = answers_reg;
        is_resp_next = is_resp_reg;
        rtype_next   = rtype_reg;
        rlen_next    = rlen_reg;
        accum_next   = accum_reg;
        found_next   = found_reg;
        stopped_next = stopped_reg;

        if (!stopped_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (offset_reg == HDR_FLAGS_OFF)
                        is_resp_next = data_byte[7];
                    else if (offset_reg == HDR_ANCNT_HI)
                        answers_next = {data_byte, 8'd0};
                    else if (offset_reg == HDR_ANCNT_LO)
                        answers_next = {answers_reg[15:8], data_byte};
                    if (offset_reg == HDR_LAST_OFF)
                    begin
                        if (!is_resp_reg || answers_reg == 16'd0)
                            stopped_next = 1'b1;
                        else
                        begin
                            phase_next = PH_QNAME;
                            skip_next  = 16'd0;
                        end
                    end
                    else
                        offset_next = offset_reg + 4'd1;
                end
                PH_QNAME, PH_ANAME:
                begin
                    priority if (skip_reg != 16'd0)
                        skip_next = skip_reg - 16'd1;
                    else if (data_byte == 8'd0)
                    begin
                        if (phase_reg == PH_QNAME)
                        begin
                            phase_next = PH_QFIXED;
                            skip_next  = Q_FIXED_SKIP;
                        end
                        else
                        begin
                            phase_next  = PH_AFIXED;
                            offset_next = 4'd0;
                        end
                    end
                    else if ((data_byte & PTR_MASK) == PTR_MASK)
                        phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                    else
                        skip_next = {8'd0, data_byte};
                end
                PH_QPTR:
                begin
                    phase_next = PH_QFIXED;
                    skip_next  = Q_FIXED_SKIP;
                end
                PH_APTR:
                begin
                    phase_next  = PH_AFIXED;
                    offset_next = 4'd0;
                end
                PH_QFIXED, PH_ADATA:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0)
                    begin
                        if (answers_reg == 16'd0)
                            stopped_next = 1'b1;
                        else
                        begin
                            answers_next = answers_reg - 16'd1;
                            phase_next   = PH_ANAME;
                            skip_next    = 16'd0;
                        end
                    end
                end
                PH_AFIXED:
                begin
                    if (offset_reg == RR_TYPE_HI)
                        rtype_next = {data_byte, 8'd0};
                    else if (offset_reg == RR_TYPE_LO)
                        rtype_next = {rtype_reg[15:8], data_byte};
                    else if (offset_reg == RR_LEN_HI)
                        rlen_next = {data_byte, 8'd0};
                    else if (offset_reg == RR_LEN_LO)
                        rlen_next = {rlen_reg[15:8], data_byte};
                    if (offset_reg >= RR_LAST_OFF)
                    begin
                        priority if (rtype_next == TYPE_A && rlen_next == A_LEN_VAL)
                        begin
                            phase_next  = PH_ADDR;
                            offset_next = 4'd0;
                            accum_next  = 32'd0;
                        end
                        else if (rlen_next == 16'd0)
                        begin
                            if (answers_reg == 16'd0)
                                stopped_next = 1'b1;
                            else
                            begin
                                answers_next = answers_reg - 16'd1;
                                phase_next   = PH_ANAME;
                                skip_next    = 16'd0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_ADATA;
                            skip_next  = rlen_next;
                        end
                    end
                    else
                        offset_next = offset_reg + 4'd1;
                end
                PH_ADDR:
                begin
                    accum_next = {accum_reg[23:0], data_byte};
                    if (offset_reg >= ADDR_LAST_OFF)
                    begin
                        found_next   = 1'b1;
                        stopped_next = 1'b1;
                    end
                    else
                        offset_next = offset_reg + 4'd1;
                end
                default:
                    stopped_next = 1'b1;
            endcase
        end
    end

    assign result.resolved = found_next;
    assign result.address  = found_next ? accum_next : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            offset_reg  <= 4'd0;
            skip_reg    <= 16'd0;
            answers_reg <= 16'd0;
            is_resp_reg <= 1'b0;
            rtype_reg   <= 16'd0;
            rlen_reg    <= 16'd0;
            accum_reg   <= 32'd0;
            found_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                phase_reg   <= PH_HEADER;
                offset_reg  <= 4'd0;
                skip_reg    <= 16'd0;
                answers_reg <= 16'd0;
                is_resp_reg <= 1'b0;
                rtype_reg   <= 16'd0;
                rlen_reg    <= 16'd0;
                accum_reg   <= 32'd0;
                found_reg   <= 1'b0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                phase_reg   <= phase_next;
                offset_reg  <= offset_next;
                skip_reg    <= skip_next;
                answers_reg <= answers_next;
                is_resp_reg <= is_resp_next;
                rtype_reg   <= rtype_next;
                rlen_reg    <= rlen_next;
                accum_reg   <= accum_next;
                found_reg   <= found_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

// File: dv/tb_dns_response_a_record_extract.sv
`timescale 1ns / 100ps

module tb_dns_response_a_record_extract;
    import dra_pkg::*;

    localparam int MODE_SPAN    = 250;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 900;
    localparam int RANDOM_BYTES = 700;

    localparam logic [15:0] RR_CNAME = 16'd5;
    localparam logic [15:0] RR_AAAA  = 16'd28;

    typedef enum logic [3:0] {
        ST_HEADER, ST_QNAME, ST_QPTR, ST_QFIXED, ST_ANAME,
        ST_APTR, ST_AFIXED, ST_ADATA, ST_ADDR
    } parse_st_t;

    typedef enum int {MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH} idle_mode_t;
    typedef enum int {NM_ROOT, NM_LABELS, NM_PTR} name_kind_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } dns_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        resolved;
    logic [31:0] address;

    dns_byte_t   payload_q[$];
    dra_result_t lookup_q[$];
    logic [7:0]  frame[$];

    int mismatches = 0;
    int bytes_taken = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // predictor state
    parse_st_t   ps_state;
    logic [3:0]  ps_offs;
    logic [15:0] ps_skip;
    logic [15:0] ps_answers;
    logic [15:0] ps_rtype;
    logic [15:0] ps_rlen;
    logic        ps_qr;
    logic [31:0] ps_addr;
    logic        ps_found;
    logic        ps_halted;

    dns_response_a_record_extract dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .resolved     (resolved),
        .address      (address)
    );

    always #5 clk = ~clk;

    task automatic clear_parser();
        ps_state   = ST_HEADER;
        ps_offs    = 4'd0;
        ps_skip    = 16'd0;
        ps_answers = 16'd0;
        ps_rtype   = 16'd0;
        ps_rlen    = 16'd0;
        ps_qr      = 1'b0;
        ps_addr    = 32'd0;
        ps_found   = 1'b0;
        ps_halted  = 1'b0;
    endtask

    task automatic next_record();
        if (ps_answers == 16'd0) begin
            ps_halted = 1'b1;
        end
        else begin
            ps_answers = ps_answers - 16'd1;
            ps_state   = ST_ANAME;
            ps_skip    = 16'd0;
        end
    endtask

    task automatic walk_name(logic [7:0] b, bit question);
        if (ps_skip != 16'd0) begin
            ps_skip = ps_skip - 16'd1;
        end
        else if (b == 8'h00) begin
            if (question) begin
                ps_state = ST_QFIXED;
                ps_skip  = Q_FIXED_SKIP;
            end
            else begin
                ps_state = ST_AFIXED;
                ps_offs  = 4'd0;
            end
        end
        else if ((b & PTR_MASK) == PTR_MASK) begin
            ps_state = question ? ST_QPTR : ST_APTR;
        end
        else begin
            ps_skip = {8'h00, b};
        end
    endtask

    task automatic predict_byte(logic [7:0] b, logic last);
        dra_result_t r;
        if (!ps_halted) begin
            case (ps_state)
                ST_HEADER:
                begin
                    if (ps_offs == HDR_FLAGS_OFF)
                        ps_qr = b[7];
                    else if (ps_offs == HDR_ANCNT_HI)
                        ps_answers = {b, 8'h00};
                    else if (ps_offs == HDR_ANCNT_LO)
                        ps_answers = {ps_answers[15:8], b};
                    if (ps_offs == HDR_LAST_OFF) begin
                        if (!ps_qr || ps_answers == 16'd0) begin
                            ps_halted = 1'b1;
                        end
                        else begin
                            ps_state = ST_QNAME;
                            ps_skip  = 16'd0;
                        end
                    end
                    else begin
                        ps_offs = ps_offs + 4'd1;
                    end
                end
                ST_QNAME: walk_name(b, 1'b1);
                ST_QPTR:
                begin
                    ps_state = ST_QFIXED;
                    ps_skip  = Q_FIXED_SKIP;
                end
                ST_ANAME: walk_name(b, 1'b0);
                ST_APTR:
                begin
                    ps_state = ST_AFIXED;
                    ps_offs  = 4'd0;
                end
                ST_QFIXED, ST_ADATA:
                begin
                    if (ps_skip != 16'd0)
                        ps_skip = ps_skip - 16'd1;
                    if (ps_skip == 16'd0)
                        next_record();
                end
                ST_AFIXED:
                begin
                    if (ps_offs == RR_TYPE_HI)
                        ps_rtype = {b, 8'h00};
                    else if (ps_offs == RR_TYPE_LO)
                        ps_rtype = {ps_rtype[15:8], b};
                    else if (ps_offs == RR_LEN_HI)
                        ps_rlen = {b, 8'h00};
                    else if (ps_offs == RR_LEN_LO)
                        ps_rlen = {ps_rlen[15:8], b};
                    if (ps_offs >= RR_LAST_OFF) begin
                        if (ps_rtype == TYPE_A && ps_rlen == A_LEN_VAL) begin
                            ps_state = ST_ADDR;
                            ps_offs  = 4'd0;
                            ps_addr  = 32'd0;
                        end
                        else if (ps_rlen == 16'd0) begin
                            next_record();
                        end
                        else begin
                            ps_state = ST_ADATA;
                            ps_skip  = ps_rlen;
                        end
                    end
                    else begin
                        ps_offs = ps_offs + 4'd1;
                    end
                end
                ST_ADDR:
                begin
                    ps_addr = {ps_addr[23:0], b};
                    if (ps_offs >= ADDR_LAST_OFF) begin
                        ps_found  = 1'b1;
                        ps_halted = 1'b1;
                    end
                    else begin
                        ps_offs = ps_offs + 4'd1;
                    end
                end
                default: ps_halted = 1'b1;
            endcase
        end
        if (last) begin
            r.resolved = ps_found;
            r.address  = ps_found ? ps_addr : 32'd0;
            lookup_q.push_back(r);
            clear_parser();
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // frame building
    task automatic put_bytes(int n);
        for (int i = 0; i < n; i++)
            frame.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_header(logic qr, logic [15:0] ancount);
        put_bytes(2);
        frame.push_back({qr, 7'($urandom_range(127))});
        put_bytes(1);
        frame.push_back(8'h00);
        frame.push_back(8'h01);
        frame.push_back(ancount[15:8]);
        frame.push_back(ancount[7:0]);
        put_bytes(4);
    endtask

    task automatic put_name(name_kind_t kind);
        int len;
        case (kind)
            NM_ROOT: frame.push_back(8'h00);
            NM_PTR:
            begin
                frame.push_back({2'b11, 6'($urandom_range(63))});
                put_bytes(1);
            end
            default:
            begin
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(9))
                        0:       len = $urandom_range(64, 191);
                        1, 2:    len = $urandom_range(7, 63);
                        default: len = $urandom_range(1, 6);
                    endcase
                    frame.push_back(8'(len));
                    put_bytes(len);
                end
                frame.push_back(8'h00);
            end
        endcase
    endtask

    task automatic put_question(name_kind_t kind);
        put_name(kind);
        put_bytes(4);
    endtask

    task automatic put_record(name_kind_t kind, logic [15:0] rtype, logic [15:0] rlen,
                              logic [31:0] ip);
        put_name(kind);
        frame.push_back(rtype[15:8]);
        frame.push_back(rtype[7:0]);
        frame.push_back(8'h00);
        frame.push_back(8'h01);
        put_bytes(4);
        frame.push_back(rlen[15:8]);
        frame.push_back(rlen[7:0]);
        if (rtype == TYPE_A && rlen == A_LEN_VAL) begin
            frame.push_back(ip[31:24]);
            frame.push_back(ip[23:16]);
            frame.push_back(ip[15:8]);
            frame.push_back(ip[7:0]);
        end
        else begin
            put_bytes(rlen);
        end
    endtask

    task automatic cut_frame(int n);
        while (frame.size() > n)
            void'(frame.pop_back());
    endtask

    task automatic send_frame();
        dns_byte_t item;
        foreach (frame[i]) begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            payload_q.push_back(item);
        end
        frame.delete();
    endtask

    function automatic name_kind_t any_name();
        return name_kind_t'($urandom_range(2));
    endfunction

    task automatic put_random_response();
        int n_rec;
        int n_ann;
        int pick;
        int len;
        n_rec = $urandom_range(1, 4);
        pick  = $urandom_range(9);
        if (pick == 0)
            n_ann = n_rec + $urandom_range(1, 3);
        else if (pick == 1 && n_rec > 1)
            n_ann = n_rec - 1;
        else
            n_ann = n_rec;
        put_header(1'b1, 16'(n_ann));
        put_question(any_name());
        for (int i = 0; i < n_rec; i++) begin
            pick = $urandom_range(9);
            if (pick < 5) begin
                put_record(any_name(), TYPE_A, A_LEN_VAL, $urandom());
            end
            else if (pick < 7) begin
                len = $urandom_range(0, 15);
                if (len == 4)
                    len = 16;
                put_record(any_name(), TYPE_A, 16'(len), 32'd0);
            end
            else begin
                len = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
                put_record(any_name(), 16'($urandom_range(2, 65535)), 16'(len), 32'd0);
            end
        end
        if ($urandom_range(3) == 0)
            put_bytes($urandom_range(1, 6));
    endtask

    function automatic idle_mode_t traffic_mode();
        return idle_mode_t'((bytes_taken / MODE_SPAN) % 4);
    endfunction

    function automatic bit sender_gap();
        case (traffic_mode())
            MODE_SEND_IDLE: return $urandom_range(99) < 53;
            MODE_BOTH:      return $urandom_range(99) < 37;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (traffic_mode())
            MODE_RECV_STALL: return $urandom_range(99) < 53;
            MODE_BOTH:       return $urandom_range(99) < 37;
            default:         return 1'b0;
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        dns_byte_t nxt;
        if (!rst_n) begin
            byte_valid <= 1'b0;
            data_byte  <= 8'h00;
            last_byte  <= 1'b0;
        end
        else begin
            if (byte_valid && !byte_stall) begin
                predict_byte(data_byte, last_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (!byte_valid || !byte_stall) begin
                if (payload_q.size() != 0 && !sender_gap()) begin
                    nxt = payload_q.pop_front();
                    byte_valid <= 1'b1;
                    data_byte  <= nxt.data;
                    last_byte  <= nxt.last;
                end
                else begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n) begin
        dra_result_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
        end
        else begin
            if (result_valid && !result_stall) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result resolved=%0b address=%h",
                                              resolved, address));
                end
                else begin
                    want = lookup_q.pop_front();
                    if (resolved !== want.resolved)
                        report_mismatch($sformatf("resolved %0b, expected %0b",
                                                  resolved, want.resolved));
                    if (address !== want.address)
                        report_mismatch($sformatf("address %h, expected %h",
                                                  address, want.address));
                end
            end
            // one long hold-off so the block backs up into the request side
            if (!hold_done && bytes_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= receiver_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int base;
        int pick;
        clear_parser();

        // short header, bare header
        frame.push_back(8'h00);
        send_frame();
        frame.push_back(8'hFF);
        send_frame();
        put_header(1'b1, 16'd1);
        send_frame();
        // not a response, no answers
        put_header(1'b0, 16'd1);
        put_question(NM_LABELS);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h0A000001);
        send_frame();
        put_header(1'b1, 16'd0);
        put_question(NM_LABELS);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h0A000001);
        send_frame();
        // plain hits, address extremes
        put_header(1'b1, 16'd1);
        put_question(NM_LABELS);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'hFFFF_FFFF);
        send_frame();
        put_header(1'b1, 16'hFF01);
        put_question(NM_PTR);
        put_record(NM_LABELS, TYPE_A, A_LEN_VAL, 32'h0000_0000);
        send_frame();
        // label lengths in the 0x40..0xBF range
        put_header(1'b1, 16'd1);
        frame.push_back(8'h40);
        put_bytes(64);
        frame.push_back(8'hBF);
        put_bytes(191);
        frame.push_back(8'h00);
        put_bytes(4);
        put_record(NM_ROOT, TYPE_A, A_LEN_VAL, 32'hC0A8_0001);
        send_frame();
        // skipped records before the hit
        put_header(1'b1, 16'd2);
        put_question(NM_PTR);
        put_record(NM_PTR, RR_CNAME, 16'd6, 32'd0);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h0808_0808);
        send_frame();
        put_header(1'b1, 16'd3);
        put_question(NM_ROOT);
        put_record(NM_PTR, TYPE_A, 16'd16, 32'd0);
        put_record(NM_ROOT, RR_AAAA, 16'd0, 32'd0);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h7F00_0001);
        send_frame();
        // answer count runs out before the A record
        put_header(1'b1, 16'd1);
        put_question(NM_PTR);
        put_record(NM_PTR, RR_CNAME, 16'd2, 32'd0);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h0102_0304);
        send_frame();
        // trailing bytes after the hit are ignored
        put_header(1'b1, 16'd2);
        put_question(NM_LABELS);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h0102_0304);
        put_bytes(20);
        send_frame();
        // payload ends in the address, the fixed fields, a name
        put_header(1'b1, 16'd1);
        put_question(NM_LABELS);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'h55AA_55AA);
        cut_frame(frame.size() - 2);
        send_frame();
        put_header(1'b1, 16'd1);
        put_question(NM_PTR);
        put_record(NM_PTR, TYPE_A, A_LEN_VAL, 32'hAA55_AA55);
        cut_frame(frame.size() - 8);
        send_frame();
        put_header(1'b1, 16'd1);
        frame.push_back(8'h05);
        put_bytes(2);
        send_frame();

        base = payload_q.size();
        while (payload_q.size() < base + RANDOM_BYTES) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                put_random_response();
            end
            else if (pick < 85) begin
                put_header(1'b0, 16'($urandom_range(1, 3)));
                put_question(any_name());
                put_bytes($urandom_range(0, 20));
            end
            else if (pick < 90) begin
                put_header(1'b1, 16'd0);
                put_bytes($urandom_range(0, 20));
            end
            else begin
                put_bytes($urandom_range(1, 30));
            end
            if ($urandom_range(99) < 15)
                cut_frame($urandom_range(1, frame.size()));
            send_frame();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (payload_q.size() != 0 || byte_valid || lookup_q.size() != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dra_pkg.sv
hw/rtl/dra_parse.sv
hw/rtl/dns_response_a_record_extract.sv
dv/tb_dns_response_a_record_extract.sv
